// ----- rtl/bsil_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Package for the bounded sorted insert list.
// Holds the entry and cell control types and the dump result bound.
// No dependencies.
package bsil_pkg;

  // Key and tag widths are fixed by the request format.
  localparam int unsigned KeyW = 16;
  localparam int unsigned TagW = 16;
  localparam int unsigned LimitW = 5;

  // A dump reports at most this many entries.
  localparam int unsigned MaxResults = 16;

  // Request type codes.
  localparam logic ReqInsert = 1'b0;
  localparam logic ReqDump   = 1'b1;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [TagW-1:0] tag;
  } entry_t;

  // Broadcast from the controller to every cell of the chain.
  typedef struct packed {
    logic   ins;        // an insert request is applied this cycle
    logic   rot;        // the valid part of the chain rotates toward cell 0
    logic   append;     // the new entry goes behind the last stored entry
    entry_t new_entry;  // the entry being inserted
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ----- rtl/bounded_sorted_insert_list.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Top level of the bounded sorted insert list: controller and chain of cells.
// Depends on bsil_pkg and bsil_cell.
//
//  Channel   Handshake              Payload
//  request   start / busy           req_type_i, sort_key_i, student_ref_i
//  result    result_valid_o         kept_o .. last_o (one cycle, no stall)
//  config    list_limit_we_i        list_limit_i
//
// An insert result is registered and shows in the next cycle; busy stays low,
// so inserts may follow every cycle.
// A dump of n entries rotates the chain once per cycle with busy high until the
// last rotation; each of the first MaxResults steps gives a registered result.
// A dump of an empty list gives its single result the cycle after it is taken.
// Reset empties the list and sets the limit to 16; stored keys are
// not cleared. The result side cannot stall.
module bounded_sorted_insert_list #(
  parameter int unsigned CAPACITY = 16,
  localparam int unsigned CntW = $clog2(CAPACITY + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          req_type_i,
  input  logic [bsil_pkg::KeyW-1:0]     sort_key_i,
  input  logic [bsil_pkg::TagW-1:0]     student_ref_i,
  input  logic                          list_limit_we_i,
  input  logic [bsil_pkg::LimitW-1:0]   list_limit_i,
  output logic                          result_valid_o,
  output logic                          kept_o,
  output logic                          evicted_valid_o,
  output logic [bsil_pkg::TagW-1:0]     evicted_ref_o,
  output logic [CntW-1:0]               count_now_o,
  output logic                          entry_valid_o,
  output logic [bsil_pkg::KeyW-1:0]     entry_key_o,
  output logic [bsil_pkg::TagW-1:0]     entry_ref_o,
  output logic                          last_o
);

  localparam int unsigned LimW = (CntW > bsil_pkg::LimitW) ? CntW : bsil_pkg::LimitW;
  localparam logic [LimW-1:0] CapLim = LimW'(CAPACITY);
  localparam logic [LimW-1:0] ResLast = LimW'(bsil_pkg::MaxResults - 1);

  localparam logic StIdle = 1'b0;
  localparam logic StDump = 1'b1;

  logic                 state_q, state_d;
  logic [CntW-1:0]      count_q, count_d;
  logic [CntW-1:0]      idx_q, idx_d;
  logic [bsil_pkg::LimitW-1:0] limit_q;

  bsil_pkg::cell_ctrl_t ctrl;
  bsil_pkg::entry_t     entry   [CAPACITY];
  logic [CAPACITY-1:0]  valid, is_last, cond, ge, le;

  logic                 accept, do_insert, do_dump;
  logic [LimW-1:0]      limit_ext, eff_limit;
  logic                 full, append;
  logic [bsil_pkg::TagW-1:0] last_tag;
  logic                 dump_step_last, dump_emit, dump_res_last;

  // Result registers.
  logic                 res_valid_q, res_valid_d;
  logic                 kept_q, kept_d, ev_q, ev_d, ent_v_q, ent_v_d, last_q, last_d;
  logic [bsil_pkg::TagW-1:0] evref_q, evref_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  bsil_pkg::entry_t     ent_q, ent_d;

  assign busy      = (state_q == StDump);
  assign accept    = start && !busy;
  assign do_insert = accept && (req_type_i == bsil_pkg::ReqInsert);
  assign do_dump   = accept && (req_type_i == bsil_pkg::ReqDump);

  // Effective limit: zero counts as one, anything above capacity as capacity.
  assign limit_ext = LimW'(limit_q);
  always_comb begin
    priority if (limit_ext == '0) begin
      eff_limit = LimW'(1);
    end else if (limit_ext > CapLim) begin
      eff_limit = CapLim;
    end else begin
      eff_limit = limit_ext;
    end
  end
  assign full = LimW'(count_q) >= eff_limit;

  // Occupancy flags and neighbor wiring of the chain.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    bsil_pkg::entry_t prev, next;
    logic             cond_prev;

    assign valid[i]   = count_q > CntW'(i);
    assign is_last[i] = count_q == CntW'(i + 1);

    if (i == 0) begin : g_first
      assign prev      = '0;
      assign cond_prev = 1'b0;
    end else begin : g_mid
      assign prev      = entry[i-1];
      assign cond_prev = cond[i-1];
    end

    if (i == CAPACITY - 1) begin : g_end
      assign next = '0;
    end else begin : g_inner
      assign next = entry[i+1];
    end

    bsil_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .valid_i     (valid[i]),
      .is_last_i   (is_last[i]),
      .cond_prev_i (cond_prev),
      .prev_i      (prev),
      .next_i      (next),
      .head_i      (entry[0]),
      .entry_o     (entry[i]),
      .cond_o      (cond[i]),
      .ge_o        (ge[i]),
      .le_o        (le[i])
    );
  end

  // Append when the key is above the first key and not below the last one.
  assign append = (count_q != '0) && !ge[0] && |(is_last & le);

  // Tag of the last stored entry, picked by the one-hot last flag.
  always_comb begin
    last_tag = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (is_last[i]) begin
        last_tag = last_tag | entry[i].tag;
      end
    end
  end

  // Broadcast control to the cells.
  always_comb begin
    ctrl.ins           = do_insert;
    ctrl.rot           = busy;
    ctrl.append        = append;
    ctrl.new_entry.key = sort_key_i;
    ctrl.new_entry.tag = student_ref_i;
  end

  // Dump step bookkeeping: one rotation per cycle, first results reported.
  assign dump_step_last = (idx_q + CntW'(1)) == count_q;
  assign dump_emit      = LimW'(idx_q) <= ResLast;
  assign dump_res_last  = dump_step_last || (LimW'(idx_q) == ResLast);

  // Sequencing and result selection.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    res_valid_d = 1'b0;
    kept_d      = 1'b0;
    ev_d        = 1'b0;
    evref_d     = '0;
    cnt_d       = count_q;
    ent_v_d     = 1'b0;
    ent_d       = '0;
    last_d      = 1'b1;
    unique case (state_q)
      StIdle: begin
        if (do_insert) begin
          res_valid_d = 1'b1;
          if (full) begin
            kept_d  = !append;
            ev_d    = !append;
            evref_d = append ? '0 : last_tag;
          end else begin
            kept_d  = 1'b1;
            count_d = count_q + CntW'(1);
          end
          cnt_d = full ? count_q : count_q + CntW'(1);
        end else if (do_dump) begin
          if (count_q == '0) begin
            res_valid_d = 1'b1;
          end else begin
            state_d = StDump;
            idx_d   = '0;
          end
        end
      end
      StDump: begin
        res_valid_d = dump_emit;
        ent_v_d     = 1'b1;
        ent_d       = entry[0];
        last_d      = dump_res_last;
        idx_d       = idx_q + CntW'(1);
        if (dump_step_last) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      idx_q       <= '0;
      limit_q     <= bsil_pkg::LimitW'(16);
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      res_valid_q <= res_valid_d;
      if (list_limit_we_i) begin
        limit_q <= list_limit_i;
      end
    end
  end

  // Result payload registers.
  always_ff @(posedge clk_i) begin
    kept_q  <= kept_d;
    ev_q    <= ev_d;
    evref_q <= evref_d;
    cnt_q   <= cnt_d;
    ent_v_q <= ent_v_d;
    ent_q   <= ent_d;
    last_q  <= last_d;
  end

  assign result_valid_o  = res_valid_q;
  assign kept_o          = kept_q;
  assign evicted_valid_o = ev_q;
  assign evicted_ref_o   = evref_q;
  assign count_now_o     = cnt_q;
  assign entry_valid_o   = ent_v_q;
  assign entry_key_o     = ent_q.key;
  assign entry_ref_o     = ent_q.tag;
  assign last_o          = last_q;

`ifndef SYNTHESIS
  // The count never passes the chain length.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    LimW'(count_q) <= CapLim)
    else $error("entry count above capacity");

  // An insert gives a single result in the next cycle.
  a_insert_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_insert |=> (result_valid_o && last_o && !entry_valid_o))
    else $error("insert result missing");

  // A dump never changes the number of entries.
  a_dump_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> $stable(count_q))
    else $error("count changed during dump");

  // An eviction only happens when the new entry was stored.
  a_evict_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && evicted_valid_o) |-> kept_o)
    else $error("eviction without a kept entry");
`endif

endmodule
`default_nettype wire

// ----- rtl/bsil_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// One cell of the sorted chain: holds one key and tag and compares them
// against the broadcast key. Depends on bsil_pkg.
module bsil_cell (
  input  logic                clk_i,
  input  bsil_pkg::cell_ctrl_t ctrl_i,
  input  logic                valid_i,
  input  logic                is_last_i,
  input  logic                cond_prev_i,
  input  bsil_pkg::entry_t    prev_i,
  input  bsil_pkg::entry_t    next_i,
  input  bsil_pkg::entry_t    head_i,
  output bsil_pkg::entry_t    entry_o,
  output logic                cond_o,
  output logic                ge_o,
  output logic                le_o
);

  bsil_pkg::entry_t entry_d, entry_q;

  // Local compares against the key being inserted.
  assign ge_o = entry_q.key >= ctrl_i.new_entry.key;
  assign le_o = entry_q.key <= ctrl_i.new_entry.key;

  // This cell is at or behind the insert position. Unused cells always are.
  assign cond_o = !valid_i || (ge_o && !ctrl_i.append);

  // Next content: shift in from the left on insert, from the right on rotate.
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins && cond_o) begin
      entry_d = cond_prev_i ? prev_i : ctrl_i.new_entry;
    end else if (ctrl_i.rot && valid_i) begin
      entry_d = is_last_i ? head_i : next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule
`default_nettype wire
